/* rtl/sprite_line_evaluator_defines.svh */
// Assertion macros shared by the sprite line evaluator checkers
`ifndef SPRITE_LINE_EVALUATOR_DEFINES_SVH
`define SPRITE_LINE_EVALUATOR_DEFINES_SVH

// Clock and reset qualifier for every concurrent property
`define SLE_CLK_RST @(posedge clk_i) disable iff (!rst_ni)

// Labeled concurrent assertion that reports through $error
`define SLE_ASSERT(label, prop, msg) \
  label: assert property (`SLE_CLK_RST prop) else $error(msg);

`endif

/* rtl/sle_pkg.sv */
// Shared types, constants and tables of the sprite line evaluator
`default_nettype none

package sle_pkg;

  localparam int unsigned SPRITE_ENTRIES_DEF = 32;
  localparam int unsigned LINE_LIMIT_DEF     = 4;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0] END_Y    = 8'hD0;
  localparam logic [7:0] WRAP_Y   = 8'hE0;
  localparam int unsigned EARLY_CLK_BIT = 7;
  localparam logic signed [8:0] EARLY_SHIFT = 9'sd32;
  localparam logic [8:0] DISPLAY_HEIGHT_RST = 9'd192;

  // Per sprite mode: 0 8x8, 1 8x8 zoomed, 2 16x16, 3 16x16 zoomed
  localparam logic [7:0] ROW_MASK  [4] = '{8'h07, 8'h07, 8'h0F, 8'h0F};
  localparam logic [7:0] NAME_KEEP [4] = '{8'hFF, 8'hFF, 8'hFC, 8'hFC};
  localparam logic       ROW_SHIFT [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [5:0] HEIGHT    [4] = '{6'd8, 6'd16, 6'd16, 6'd32};

  typedef enum logic [1:0] {
    REG_SPRITE_MODE    = 2'd0,
    REG_PATTERN_BASE   = 2'd1,
    REG_NO_LIMIT       = 2'd2,
    REG_DISPLAY_HEIGHT = 2'd3
  } sle_reg_e;

  typedef struct packed {
    logic [1:0]  sprite_mode;
    logic [13:0] pattern_base;
    logic        no_sprite_limit;
    logic [8:0]  display_height;
  } sle_cfg_t;

  // Classified entry handed from the front to the back
  typedef struct packed {
    logic       hit;
    logic [4:0] slot;
    logic       done;
    logic       status_valid;
    logic       overflow;
    logic [4:0] last_entry;
    logic [4:0] row_ofs;
    logic [7:0] attr_x;
    logic [7:0] attr_name;
    logic [7:0] attr_color;
  } sle_job_t;

  typedef struct packed {
    logic     push;
    sle_job_t job;
  } sle_push_t;

endpackage

`default_nettype wire

/* rtl/sle_in_if.sv */
// Input channel: one sprite attribute entry per word
`default_nettype none

interface sle_in_if;
  logic       valid;
  logic       ready;
  logic       first_of_line;
  logic [8:0] scan_line;
  logic [7:0] attr_y;
  logic [7:0] attr_x;
  logic [7:0] attr_name;
  logic [7:0] attr_color;

  modport source (
    output valid, first_of_line, scan_line, attr_y, attr_x, attr_name, attr_color,
    input  ready
  );
  modport sink (
    input  valid, first_of_line, scan_line, attr_y, attr_x, attr_name, attr_color,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/sle_out_if.sv */
// Output channel: one evaluation result per word
`default_nettype none

interface sle_out_if;
  logic              valid;
  logic              ready;
  logic              sprite_hit;
  logic [4:0]        sprite_slot;
  logic signed [8:0] x_position;
  logic [7:0]        color_attr;
  logic [13:0]       pattern_address;
  logic              line_done;
  logic              overflow;
  logic [4:0]        last_entry;
  logic              status_valid;

  modport source (
    output valid, sprite_hit, sprite_slot, x_position, color_attr, pattern_address,
           line_done, overflow, last_entry, status_valid,
    input  ready
  );
  modport sink (
    input  valid, sprite_hit, sprite_slot, x_position, color_attr, pattern_address,
           line_done, overflow, last_entry, status_valid,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/sprite_line_evaluator.sv */
// Top level of the sprite line evaluator: register port, front, queue and back
// Path: an accepted word is written into the queue, then loaded into the output register.
// Throughput: one attribute word per cycle; the front takes a new word while the
//   output register waits, until the two-entry queue is full.
// Reset: asynchronous active low; clears queue, output valid and line state (no
//   line active), and sets the registers to their defaults (display height 192).
`default_nettype none

module sprite_line_evaluator #(
  parameter int unsigned SPRITE_ENTRIES = sle_pkg::SPRITE_ENTRIES_DEF,
  parameter int unsigned LINE_LIMIT     = sle_pkg::LINE_LIMIT_DEF,
  parameter int unsigned QUEUE_DEPTH    = sle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  sle_in_if.sink                           in_i,
  sle_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sle_pkg::PADDR_W-1:0] paddr,
  input  wire logic [sle_pkg::PDATA_W-1:0] pwdata,
  output logic      [sle_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  sle_pkg::sle_cfg_t  cfg_q;
  sle_pkg::sle_reg_e  reg_sel;
  sle_pkg::sle_push_t push;
  sle_pkg::sle_job_t  head;
  logic               cfg_wr;
  logic               full;
  logic               empty;
  logic               pop;

  // Register port: zero wait states, word-aligned decode on the upper address bits
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = sle_pkg::sle_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_mode     <= 2'd0;
      cfg_q.pattern_base    <= 14'd0;
      cfg_q.no_sprite_limit <= 1'b0;
      cfg_q.display_height  <= sle_pkg::DISPLAY_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        sle_pkg::REG_SPRITE_MODE:    cfg_q.sprite_mode     <= pwdata[1:0];
        sle_pkg::REG_PATTERN_BASE:   cfg_q.pattern_base    <= pwdata[13:0];
        sle_pkg::REG_NO_LIMIT:       cfg_q.no_sprite_limit <= pwdata[0];
        sle_pkg::REG_DISPLAY_HEIGHT: cfg_q.display_height  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sle_pkg::REG_SPRITE_MODE:    prdata = 32'(cfg_q.sprite_mode);
      sle_pkg::REG_PATTERN_BASE:   prdata = 32'(cfg_q.pattern_base);
      sle_pkg::REG_NO_LIMIT:       prdata = 32'(cfg_q.no_sprite_limit);
      sle_pkg::REG_DISPLAY_HEIGHT: prdata = 32'(cfg_q.display_height);
      default:                     prdata = '0;
    endcase
  end

  // Front: line tracking (found count, entry index, line closed) and
  // classification of each word into hit, miss, end of list, overflow,
  // off-screen or ignored; advance state on every accepted word.
  sle_front #(
    .SPRITE_ENTRIES (SPRITE_ENTRIES),
    .LINE_LIMIT     (LINE_LIMIT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push)
  );

  // Queue: decouple classification from result formation so either side
  // may stall on its own.
  sle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (empty)
  );

  // Back: build the pattern row address and X start, hold the result
  // in the output register until the consumer takes it.
  sle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .job_i   (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* rtl/sle_front.sv */
// Front end: accepts attribute entries, tracks line state, classifies each entry
`default_nettype none

module sle_front #(
  parameter int unsigned SPRITE_ENTRIES = sle_pkg::SPRITE_ENTRIES_DEF,
  parameter int unsigned LINE_LIMIT     = sle_pkg::LINE_LIMIT_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sle_in_if.sink                in_i,
  input  wire sle_pkg::sle_cfg_t cfg_i,
  input  wire logic             full_i,
  output sle_pkg::sle_push_t    push_o
);

  localparam int unsigned CNT_W = $clog2(SPRITE_ENTRIES + 1);

  logic [CNT_W-1:0] found_q, found_d, found_eff;
  logic [CNT_W-1:0] idx_q, idx_d, idx_eff, idx_inc;
  logic             closed_q, closed_d, closed_eff;
  logic             push;
  logic signed [9:0]  y_pos;
  logic signed [10:0] diff;
  logic             covered;
  logic             at_limit;
  sle_pkg::sle_job_t job;

  assign in_i.ready = !full_i;
  assign push       = in_i.valid && !full_i;

  always_comb begin
    found_eff  = in_i.first_of_line ? '0 : found_q;
    idx_eff    = in_i.first_of_line ? '0 : idx_q;
    closed_eff = in_i.first_of_line ? 1'b0 : closed_q;
    idx_inc    = idx_eff + 1'b1;

    // Y above the wrap point stands for a position above the top edge
    y_pos = (in_i.attr_y > sle_pkg::WRAP_Y) ? $signed({2'b11, in_i.attr_y})
                                            : $signed({2'b00, in_i.attr_y});
    diff  = $signed({2'b00, in_i.scan_line}) - $signed({y_pos[9], y_pos});
    covered = !diff[10] &&
              (diff[9:0] < 10'(sle_pkg::HEIGHT[cfg_i.sprite_mode]));
    at_limit = (32'(found_eff) >= LINE_LIMIT) && !cfg_i.no_sprite_limit;

    job = '0;
    job.row_ofs    = diff[4:0];
    job.attr_x     = in_i.attr_x;
    job.attr_name  = in_i.attr_name;
    job.attr_color = in_i.attr_color;

    found_d  = found_eff;
    idx_d    = idx_eff;
    closed_d = closed_eff;

    if (!closed_eff) begin
      if (in_i.scan_line >= cfg_i.display_height) begin
        // Off-screen line: close without touching status
        job.done = 1'b1;
        closed_d = 1'b1;
      end else if (in_i.attr_y == sle_pkg::END_Y) begin
        job.done         = 1'b1;
        job.status_valid = 1'b1;
        job.last_entry   = 5'(idx_eff);
        closed_d         = 1'b1;
      end else if (covered && at_limit) begin
        job.done         = 1'b1;
        job.status_valid = 1'b1;
        job.overflow     = 1'b1;
        job.last_entry   = 5'(idx_eff);
        closed_d         = 1'b1;
      end else begin
        if (covered) begin
          job.hit = 1'b1;
          job.slot = 5'(found_eff);
          found_d = found_eff + 1'b1;
        end
        idx_d = idx_inc;
        if (idx_inc == CNT_W'(SPRITE_ENTRIES)) begin
          job.done         = 1'b1;
          job.status_valid = 1'b1;
          job.last_entry   = 5'(idx_inc);
          closed_d         = 1'b1;
        end
      end
    end
  end

  assign push_o.push = push;
  assign push_o.job  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= '0;
      idx_q    <= '0;
      closed_q <= 1'b1;
    end else if (push) begin
      found_q  <= found_d;
      idx_q    <= idx_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/sle_queue.sv */
// Small FIFO of classified entries between front and back
`default_nettype none

module sle_queue #(
  parameter int unsigned DEPTH = sle_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sle_pkg::sle_push_t push_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output sle_pkg::sle_job_t       data_o,
  output logic                    empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sle_pkg::sle_job_t mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sle_back.sv */
// Back end: forms pattern address and X start, holds the output register
`default_nettype none

module sle_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sle_pkg::sle_cfg_t cfg_i,
  input  wire sle_pkg::sle_job_t job_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  sle_out_if.source              out_o
);

  logic              out_valid_q;
  logic              load;
  logic [7:0]        name_v;
  logic [4:0]        row_v;
  logic [13:0]       addr_v;
  logic signed [8:0] x_v;

  assign load  = !empty_i && (!out_valid_q || out_o.ready);
  assign pop_o = load;

  always_comb begin
    name_v = job_i.attr_name & sle_pkg::NAME_KEEP[cfg_i.sprite_mode];
    row_v  = (job_i.row_ofs >> sle_pkg::ROW_SHIFT[cfg_i.sprite_mode]) &
             sle_pkg::ROW_MASK[cfg_i.sprite_mode][4:0];
    // Lower half of a 16-pixel sprite lives in the next name
    if (row_v[3]) begin
      name_v[0] = 1'b1;
    end
    addr_v = cfg_i.pattern_base | {3'b000, name_v[7:0], row_v[2:0]};
    x_v    = $signed({1'b0, job_i.attr_x}) -
             (job_i.attr_color[sle_pkg::EARLY_CLK_BIT] ? sle_pkg::EARLY_SHIFT : 9'sd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_o.sprite_hit      <= job_i.hit;
      out_o.sprite_slot     <= job_i.hit ? job_i.slot : 5'd0;
      out_o.x_position      <= job_i.hit ? x_v : 9'sd0;
      out_o.color_attr      <= job_i.hit ? job_i.attr_color : 8'd0;
      out_o.pattern_address <= job_i.hit ? addr_v : 14'd0;
      out_o.line_done       <= job_i.done;
      out_o.overflow        <= job_i.overflow;
      out_o.last_entry      <= job_i.last_entry;
      out_o.status_valid    <= job_i.status_valid;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/sle_checker.sv */
// Port-level checker for the sprite line evaluator and its bind
`default_nettype none
`include "sprite_line_evaluator_defines.svh"

module sle_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              sprite_hit,
  input wire logic [4:0]        sprite_slot,
  input wire logic signed [8:0] x_position,
  input wire logic [7:0]        color_attr,
  input wire logic [13:0]       pattern_address,
  input wire logic              line_done,
  input wire logic              overflow,
  input wire logic [4:0]        last_entry,
  input wire logic              status_valid
);

  `SLE_ASSERT(a_ovf_no_hit, out_valid && overflow |-> !sprite_hit && status_valid, "overflow word carries a hit")
  `SLE_ASSERT(a_status_ends_line, out_valid && status_valid |-> line_done, "status update without line end")
  `SLE_ASSERT(a_miss_zero, out_valid && !sprite_hit |-> sprite_slot == 5'd0 && x_position == 9'sd0 && color_attr == 8'd0 && pattern_address == 14'd0, "miss word carries sprite data")
  `SLE_ASSERT(a_no_status_zero, out_valid && !status_valid |-> !overflow && last_entry == 5'd0, "status fields set without status update")
  `SLE_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid && $stable(pattern_address) && $stable(last_entry), "stalled output word changed")

endmodule

bind sprite_line_evaluator sle_checker u_sle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .sprite_hit      (out_o.sprite_hit),
  .sprite_slot     (out_o.sprite_slot),
  .x_position      (out_o.x_position),
  .color_attr      (out_o.color_attr),
  .pattern_address (out_o.pattern_address),
  .line_done       (out_o.line_done),
  .overflow        (out_o.overflow),
  .last_entry      (out_o.last_entry),
  .status_valid    (out_o.status_valid)
);

`default_nettype wire
